// ===== hdl/s2d_pkg.sv =====
// ----------------------------------------------------------------------------
// s2d_pkg: shared types and constants for the integer-to-decimal text block
// Digit width, field widths and the BCD correction used by the shift unit.
// ----------------------------------------------------------------------------
package s2d_pkg;

  localparam int DIGIT_W = 4;
  localparam int CHAR_W  = 6;
  localparam int LEN_W   = 4;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [LEN_W-1:0]   len_t;

  localparam char_t CHAR_ZERO  = 6'd48;
  localparam char_t CHAR_MINUS = 6'd45;

  // A BCD digit of five or more gets three added before the doubling shift,
  // so that it carries correctly into the next digit.
  function automatic digit_t s2d_adj(input digit_t d);
    digit_t r;
    if (d >= digit_t'(5)) begin
      r = d + digit_t'(3);
    end else begin
      r = d;
    end
    return r;
  endfunction

endpackage

// ===== hdl/s2d_dabble.sv =====
// ----------------------------------------------------------------------------
// s2d_dabble: iterative binary-to-BCD shift unit
// Shifts the magnitude in one bit per cycle with add-three correction, then
// hands out the digits most significant first by shifting one digit a step.
// ----------------------------------------------------------------------------
module s2d_dabble #(
  parameter int VALUE_WIDTH = 32,
  parameter int NDIG        = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  logic [VALUE_WIDTH-1:0] mag,
  input  logic                   digit_shift,
  output logic                   busy,
  output s2d_pkg::digit_t        top_digit
);
  import s2d_pkg::*;

  localparam int BCD_W = DIGIT_W * NDIG;
  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] mag_r, mag_nxt;
  logic [BCD_W-1:0]       bcd_r, bcd_nxt;
  logic [BCD_W-1:0]       bcd_adj;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[DIGIT_W*i +: DIGIT_W] = s2d_adj(bcd_r[DIGIT_W*i +: DIGIT_W]);
    end
  end

  always_comb begin
    mag_nxt  = mag_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (load) begin
      mag_nxt  = mag;
      bcd_nxt  = '0;
      cnt_nxt  = CNT_W'(VALUE_WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      mag_nxt = {mag_r[VALUE_WIDTH-2:0], 1'b0};
      bcd_nxt = {bcd_adj[BCD_W-2:0], mag_r[VALUE_WIDTH-1]};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end else if (digit_shift) begin
      bcd_nxt = {bcd_r[BCD_W-DIGIT_W-1:0], digit_t'(0)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
  end

  assign busy      = busy_r;
  assign top_digit = bcd_r[BCD_W-1 -: DIGIT_W];

endmodule

// ===== hdl/signed_int_to_decimal_ascii_core.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core: signed integer to decimal ASCII text
// Converts one two's-complement value into its decimal characters, one beat
// per character, sign first, most significant digit first.
//
//   channel | dir | tdata fields (low bit up)            | tlast
//   in_     | in  | value[VALUE_WIDTH-1:0], zero pad      | -
//   out_    | out | character[5:0], text_length[9:6], pad | last character
//
// An item passes through an accept, the BCD shift unit, a scan that strips
// leading zeros, a sign beat when negative and one beat per digit.
// The shift unit's doubling loop takes in one magnitude bit per cycle.
// Reset is synchronous and active low; it clears only control state.
// in_tready is high only between items; out_tready low stalls the emission.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // value (VALUE_WIDTH bits), zero padded to whole bytes
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]  in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // character [5:0], text_length [9:6], zeros [15:10]
  output logic [15:0]                       out_tdata,
  output logic                              out_tlast
);
  import s2d_pkg::*;

  // Digits in the largest magnitude, 2^(VALUE_WIDTH-1), with margin.
  localparam int NDIG = (VALUE_WIDTH * 302) / 1000 + 1;
  localparam int ND_W = $clog2(NDIG + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CONV = 5'b00010,
    S_SCAN = 5'b00100,
    S_SIGN = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t                 state_r, state_nxt;
  logic                   neg_r, neg_nxt;
  logic [ND_W-1:0]        ndig_r, ndig_nxt;
  len_t                   len_r, len_nxt;
  logic                   out_valid_r, out_valid_nxt;
  char_t                  out_char_r, out_char_nxt;
  len_t                   out_len_r, out_len_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [VALUE_WIDTH-1:0] value;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   accept;
  logic                   load_out;
  logic                   digit_shift;
  logic                   conv_busy;
  digit_t                 top_digit;

  assign value  = in_tdata[VALUE_WIDTH-1:0];
  // The most negative value negates to itself, which is the right magnitude.
  assign mag    = value[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - value) : value;
  assign accept = in_tvalid && in_tready;
  assign load_out = !out_valid_r || out_tready;

  s2d_dabble #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NDIG        (NDIG)
  ) u_dabble (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (accept),
    .mag         (mag),
    .digit_shift (digit_shift),
    .busy        (conv_busy),
    .top_digit   (top_digit)
  );

  always_comb begin
    state_nxt     = state_r;
    neg_nxt       = neg_r;
    ndig_nxt      = ndig_r;
    len_nxt       = len_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_len_nxt   = out_len_r;
    out_last_nxt  = out_last_r;
    digit_shift   = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          neg_nxt   = value[VALUE_WIDTH-1];
          ndig_nxt  = ND_W'(NDIG);
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        if (!conv_busy) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // Drop leading zero digits, keeping at least one.
        if (top_digit == digit_t'(0) && ndig_r > ND_W'(1)) begin
          digit_shift = 1'b1;
          ndig_nxt    = ndig_r - ND_W'(1);
        end else begin
          len_nxt   = LEN_W'(ndig_r) + LEN_W'(neg_r);
          state_nxt = neg_r ? S_SIGN : S_EMIT;
        end
      end
      S_SIGN: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_MINUS;
          out_len_nxt   = len_r;
          out_last_nxt  = 1'b0;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_ZERO + char_t'(top_digit);
          out_len_nxt   = len_r;
          out_last_nxt  = (ndig_r == ND_W'(1));
          digit_shift   = 1'b1;
          ndig_nxt      = ndig_r - ND_W'(1);
          if (ndig_r == ND_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    neg_r      <= neg_nxt;
    ndig_r     <= ndig_nxt;
    len_r      <= len_nxt;
    out_char_r <= out_char_nxt;
    out_len_r  <= out_len_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_len_r, out_char_r};
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_emit_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (ndig_r != '0))
    else $error("emit state entered with no digits left");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (conv_busy && !in_tready))
    else $error("shift unit not started after an accepted item");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_char_r != CHAR_MINUS) |->
      (out_char_r >= CHAR_ZERO && out_char_r <= CHAR_ZERO + char_t'(9)))
    else $error("character is neither a digit nor a minus sign");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_char_r == CHAR_MINUS) |-> !out_last_r)
    else $error("minus sign marked as the last character");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_len_r != '0))
    else $error("text length of zero on an output beat");
`endif

endmodule
